@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the zone row motion profile.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ZRMP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zone row motion profile: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ZRMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zone row motion profile: next-cycle check failed");

`endif

@@ hdl/zrmp_pkg.sv @@
// Shared types and constants of the zone row motion profile.
package zrmp_pkg;

  localparam int PIXEL_W    = 8;
  localparam int RESULT_W   = 8;
  localparam int ZW_REG_W   = 7;
  localparam int ZH_REG_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int ACT_OFFSET = 64;
  localparam int ACT_MAX    = 255;

  localparam logic [ZW_REG_W-1:0] ZONE_WIDTH_RESET  = 7'd10;
  localparam logic [ZH_REG_W-1:0] ZONE_HEIGHT_RESET = 9'd120;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START_E,
    ST_WAIT_E,
    ST_START_M,
    ST_WAIT_M,
    ST_EMIT
  } zrmp_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // latch pixel, issue store read
    logic update;       // accumulate, write store, step counters
    logic div_start_e;  // divide row energy by width
    logic div_start_m;  // divide row intensity by width
    logic take_e;       // keep energy quotient
    logic load_out;     // load output register
  } zrmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_end;
    logic emit;
    logic div_busy;
    logic out_free;
  } zrmp_sts_t;

endpackage

@@ hdl/zrmp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module zrmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/zrmp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module zrmp_div #(
  parameter int DW = 22,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     partial;
  logic [VW:0]     trial;

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    partial = {rem, quotient[DW-1]};
    trial   = partial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CNTW'(DW);
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      cnt  <= cnt - CNTW'(1);
      busy <= (cnt != CNTW'(1));
      if (!trial[VW]) begin
        rem      <= trial[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= partial[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/zrmp_datapath.sv @@
// Datapath: config registers, counters, row accumulators, frame store, divider, output register.
module zrmp_datapath #(
  parameter int MAX_ZONE_WIDTH  = 64,
  parameter int MAX_ZONE_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [zrmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [zrmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [zrmp_pkg::PIXEL_W-1:0]        pixel,
  input  zrmp_pkg::zrmp_cmd_t                 cmd,
  output zrmp_pkg::zrmp_sts_t                 sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [zrmp_pkg::RESULT_W-1:0]       activity,
  output logic [zrmp_pkg::RESULT_W-1:0]       row_mean,
  output logic [zrmp_pkg::RESULT_W-1:0]       row_index,
  output logic                                last_row
);

  import zrmp_pkg::*;

  localparam int DEPTH = MAX_ZONE_WIDTH * MAX_ZONE_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = MAX_ZONE_WIDTH > 1 ? $clog2(MAX_ZONE_WIDTH) : 1;
  localparam int RW    = MAX_ZONE_HEIGHT > 1 ? $clog2(MAX_ZONE_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_ZONE_WIDTH + 1);
  localparam int HW    = $clog2(MAX_ZONE_HEIGHT + 1);
  localparam int EW    = $clog2(65025 * MAX_ZONE_WIDTH + 1);
  localparam int IW    = $clog2(255 * MAX_ZONE_WIDTH + 1);

  logic [ZW_REG_W-1:0] zone_width;
  logic [ZH_REG_W-1:0] zone_height;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;

  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [EW-1:0]       energy_sum;
  logic [IW-1:0]       intensity_sum;
  logic                has_ref;
  logic [PIXEL_W-1:0]  pixel_q;

  logic [EW-1:0]       row_energy;
  logic [IW-1:0]       row_intensity;
  logic [RW-1:0]       row_q;
  logic                last_q;
  logic [EW-1:0]       q_e;

  logic [AW-1:0]       addr;
  logic [PIXEL_W-1:0]  old_px;
  logic [PIXEL_W-1:0]  diff;
  logic [2*PIXEL_W-1:0] diff_sq;
  logic [EW-1:0]       energy_new;
  logic [IW-1:0]       intensity_new;
  logic                row_end;
  logic                last;

  logic                div_busy;
  logic [EW-1:0]       div_quo;
  logic [EW-1:0]       div_dividend;

  logic [EW-1:0]       half_q;
  logic [EW-1:0]       act_diff;
  logic [RESULT_W-1:0] act_val;
  logic [RESULT_W-1:0] mean_val;
  logic [RW+7:0]       row_wide;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_width  <= ZONE_WIDTH_RESET;
      zone_height <= ZONE_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZONE_WIDTH:  zone_width  <= cfg_data[ZW_REG_W-1:0];
        REG_ZONE_HEIGHT: zone_height <= cfg_data[ZH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective zone size: zero counts as one, large values clamp to the maximum
  always_comb begin
    if (zone_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(zone_width) > MAX_ZONE_WIDTH) begin
      w_eff = WW'(MAX_ZONE_WIDTH);
    end else begin
      w_eff = WW'(zone_width);
    end
    if (zone_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(zone_height) > MAX_ZONE_HEIGHT) begin
      h_eff = HW'(MAX_ZONE_HEIGHT);
    end else begin
      h_eff = HW'(zone_height);
    end
  end

  // Store address and row / frame end detection
  always_comb begin
    addr    = AW'(32'(row) * MAX_ZONE_WIDTH + 32'(col));
    row_end = (32'(col) + 1) >= 32'(w_eff);
    last    = (32'(row) + 1) >= 32'(h_eff);
  end

  zrmp_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (addr),
    .wdata (pixel_q),
    .re    (cmd.accept),
    .raddr (addr),
    .rdata (old_px)
  );

  // Squared difference against the previous frame and running sums
  always_comb begin
    diff          = (pixel_q > old_px) ? pixel_q - old_px : old_px - pixel_q;
    diff_sq       = (2*PIXEL_W)'(diff) * (2*PIXEL_W)'(diff);
    energy_new    = energy_sum + EW'(diff_sq);
    intensity_new = intensity_sum + IW'(pixel_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel_q <= pixel;
    end
  end

  // Counters and row accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      energy_sum    <= '0;
      intensity_sum <= '0;
      has_ref       <= 1'b0;
    end else if (cmd.update) begin
      if (row_end) begin
        energy_sum    <= '0;
        intensity_sum <= '0;
        col           <= '0;
        if (last) begin
          row     <= '0;
          has_ref <= 1'b1;
        end else begin
          row <= RW'(32'(row) + 1);
        end
      end else begin
        energy_sum    <= energy_new;
        intensity_sum <= intensity_new;
        col           <= CW'(32'(col) + 1);
      end
    end
  end

  // Row totals held for the divider
  always_ff @(posedge clk) begin
    if (cmd.update && row_end) begin
      row_energy    <= energy_new;
      row_intensity <= intensity_new;
      row_q         <= row;
      last_q        <= last;
    end
  end

  assign div_dividend = cmd.div_start_e ? row_energy : EW'(row_intensity);

  zrmp_div #(
    .DW (EW),
    .VW (WW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start_e | cmd.div_start_m),
    .dividend (div_dividend),
    .divisor  (w_eff),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_e) begin
      q_e <= div_quo;
    end
  end

  // Activity: half the mean energy less the offset, clamped; mean saturates
  always_comb begin
    half_q   = q_e >> 1;
    act_diff = half_q - EW'(ACT_OFFSET);
    if (half_q < EW'(ACT_OFFSET)) begin
      act_val = '0;
    end else if (act_diff > EW'(ACT_MAX)) begin
      act_val = RESULT_W'(ACT_MAX);
    end else begin
      act_val = act_diff[RESULT_W-1:0];
    end
    if (div_quo > EW'(ACT_MAX)) begin
      mean_val = RESULT_W'(ACT_MAX);
    end else begin
      mean_val = div_quo[RESULT_W-1:0];
    end
    row_wide = {8'b0, row_q};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      activity  <= act_val;
      row_mean  <= mean_val;
      row_index <= row_wide[7:0];
      last_row  <= last_q;
    end
  end

  always_comb begin
    sts.row_end  = row_end;
    sts.emit     = has_ref;
    sts.div_busy = div_busy;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

@@ hdl/zrmp_ctrl.sv @@
// Controller state machine: sequences read, update, two divisions and output load.
module zrmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  zrmp_pkg::zrmp_sts_t sts,
  output zrmp_pkg::zrmp_cmd_t cmd
);

  import zrmp_pkg::*;

  zrmp_state_t state;
  zrmp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.row_end && sts.emit) begin
          state_next = ST_START_E;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_START_E: begin
        cmd.div_start_e = 1'b1;
        state_next      = ST_WAIT_E;
      end
      ST_WAIT_E: begin
        if (!sts.div_busy) begin
          cmd.take_e = 1'b1;
          state_next = ST_START_M;
        end
      end
      ST_START_M: begin
        cmd.div_start_m = 1'b1;
        state_next      = ST_WAIT_M;
      end
      ST_WAIT_M: begin
        if (!sts.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/zone_row_motion_profile.sv @@
// Throughput: one pixel in flight; a pixel that ends no row, or ends a reference-frame row,
// passes through accept and update only. A row-ending pixel that emits also waits while the
// shared one-bit-per-cycle divider, EW (energy sum width, 22 at the default size) bits wide,
// runs for energy, then the sum. Its result then waits in the output register; a result
// still stalled there holds the next emitting pixel back.
// Reset clears counters, sums and the reference flag; the frame store holds no reset value.
module zone_row_motion_profile #(
  parameter int MAX_ZONE_WIDTH  = 64,
  parameter int MAX_ZONE_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [zrmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zrmp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zrmp_pkg::PIXEL_W-1:0]      pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [zrmp_pkg::RESULT_W-1:0]     activity,
  output logic [zrmp_pkg::RESULT_W-1:0]     row_mean,
  output logic [zrmp_pkg::RESULT_W-1:0]     row_index,
  output logic                              last_row
);

  import zrmp_pkg::*;

  zrmp_cmd_t cmd;
  zrmp_sts_t sts;

  zrmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  zrmp_datapath #(
    .MAX_ZONE_WIDTH  (MAX_ZONE_WIDTH),
    .MAX_ZONE_HEIGHT (MAX_ZONE_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .activity  (activity),
    .row_mean  (row_mean),
    .row_index (row_index),
    .last_row  (last_row)
  );

endmodule

@@ hdl/zrmp_checker.sv @@
// Port-level checker for the zone row motion profile, with its bind.
`include "assert_macros.svh"

module zrmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] activity,
  input logic [7:0] row_mean,
  input logic [7:0] row_index,
  input logic       last_row
);

  // Leaving reset: nothing to deliver, ready for a pixel
  `ZRMP_ASSERT_NOW(a_reset_clean, clk, rst, $past(rst), !out_valid && !in_stall)

  // One pixel in flight: an accepted item stalls the input next cycle
  `ZRMP_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

  // A stalled result holds
  `ZRMP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable({activity, row_mean, row_index, last_row}))

endmodule

bind zone_row_motion_profile zrmp_checker u_zrmp_checker (.*);
